### rtl/wbps_pkg.sv
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// Used by the front end, command queue, scan engine and top level; no dependencies.
package wbps_pkg;

  // Pattern capacity and derived widths
  localparam int MaxPattern = 32;
  localparam int LenW       = $clog2(MaxPattern + 1);

  // Command queue depth
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Input opcodes
  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpChar  = 2'd1;
  localparam logic [1:0] OpByte  = 2'd2;

  // Register index of region_base (paddr[3])
  localparam logic RegIdxRegionBase = 1'b0;

  // Character codes
  localparam logic [7:0] CharQuestion = 8'h3F;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharUpperA   = 8'h41;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CaseMask     = 8'hDF;
  localparam logic [7:0] DigitTen     = 8'd10;
  localparam logic [7:0] HighNibMask  = 8'hF0;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_CHAR,
    CMD_BYTE
  } cmd_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_AFTER_Q,
    PH_AFTER_HI,
    PH_SKIP
  } phase_e;

  // Classified request handed from the front end to the scan engine
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] value;
    logic       last;
    logic       is_q;
    logic       is_space;
    logic [7:0] digit;
  } cmd_t;

  // Hex digit value of a character, modulo 256
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] res;
    res = '0;
    if (c >= CharUpperA) begin
      res = ((c - CharUpperA) & CaseMask) + DigitTen;
    end else if (c <= CharNine) begin
      res = c - CharZero;
    end
    return res;
  endfunction

endpackage

### rtl/wbps_front.sv
// Front end: accepts stream requests and classifies them into engine commands.
// Depends on wbps_pkg; feeds wbps_fifo.
module wbps_front (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 s_axis_tlast,
  input  logic                 full_i,
  output logic                 push_o,
  output wbps_pkg::cmd_t       cmd_o
);
  import wbps_pkg::*;

  logic accept;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode the opcode; drop the unused code
  always_comb begin
    cmd_o.kind     = CMD_CLEAR;
    cmd_o.value    = s_axis_tdata;
    cmd_o.last     = s_axis_tlast;
    cmd_o.is_q     = (s_axis_tdata == CharQuestion);
    cmd_o.is_space = (s_axis_tdata == CharSpace);
    cmd_o.digit    = digit_value(s_axis_tdata);
    push_o         = 1'b0;
    case (s_axis_tuser)
      OpStart: begin
        cmd_o.kind = CMD_CLEAR;
        push_o     = accept;
      end
      OpChar: begin
        cmd_o.kind = CMD_CHAR;
        push_o     = accept;
      end
      OpByte: begin
        cmd_o.kind = CMD_BYTE;
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/wbps_fifo.sv
// Short command queue between the front end and the scan engine.
// Depends on wbps_pkg for the command type and depth.
module wbps_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wbps_pkg::cmd_t       data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output wbps_pkg::cmd_t       data_o,
  input  logic                 pop_i
);
  import wbps_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/wbps_back.sv
// Scan engine: parses signature characters, shifts region bytes into the window,
// runs the masked compare and drives the result stream. Depends on wbps_pkg.
module wbps_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  wbps_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  input  logic [63:0]          region_base_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser
);
  import wbps_pkg::*;

  typedef struct packed {
    logic        found;
    logic        overflow;
    logic [31:0] offset;
  } result_t;

  // Pattern is kept newest-first: slot 0 holds the last element appended,
  // so slot j lines up with window slot j for every pattern length.
  logic [7:0]      pat_byte_q [MaxPattern];
  logic [7:0]      pat_byte_d [MaxPattern];
  logic            pat_wild_q [MaxPattern];
  logic            pat_wild_d [MaxPattern];
  logic [7:0]      win_q      [MaxPattern];
  logic [7:0]      win_d      [MaxPattern];
  logic [7:0]      win_n      [MaxPattern];

  logic [LenW-1:0] len_q, len_d;
  phase_e          phase_q, phase_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     seen_q, seen_d, seen_n;
  logic            done_q, done_d;

  logic            res_valid_q, res_valid_d;
  result_t         res_q, res_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic [63:0]     out_addr_q, out_addr_d;

  logic            res_move, exec, res_load, hit;
  logic            app_en, app_wild;
  logic [7:0]      app_byte;
  logic [31:0]     off;

  assign res_move = res_valid_q && (!out_valid_q || m_axis_tready);
  assign exec     = cmd_valid_i && (!res_valid_q || res_move);
  assign pop_o    = exec;

  // Shifted window and masked compare
  always_comb begin
    win_n[0] = cmd_i.value;
    for (int j = 1; j < MaxPattern; j++) begin
      win_n[j] = win_q[j-1];
    end
    seen_n = (seen_q == '1) ? seen_q : seen_q + 32'd1;
    hit    = (seen_n >= 32'(len_q));
    for (int j = 0; j < MaxPattern; j++) begin
      if ((LenW'(j) < len_q) && !pat_wild_q[j] && (win_n[j] != pat_byte_q[j])) begin
        hit = 1'b0;
      end
    end
    off = seen_n - 32'(len_q);
  end

  // Execute one command
  always_comb begin
    pat_byte_d = pat_byte_q;
    pat_wild_d = pat_wild_q;
    win_d      = win_q;
    len_d      = len_q;
    phase_d    = phase_q;
    ovf_d      = ovf_q;
    seen_d     = seen_q;
    done_d     = done_q;
    res_load   = 1'b0;
    res_d      = res_q;
    app_en     = 1'b0;
    app_wild   = 1'b0;
    app_byte   = '0;
    if (exec) begin
      case (cmd_i.kind)
        CMD_CLEAR: begin
          len_d   = '0;
          phase_d = PH_START;
          ovf_d   = 1'b0;
          seen_d  = '0;
          done_d  = 1'b0;
        end
        CMD_CHAR: begin
          case (phase_q)
            PH_AFTER_Q: begin
              phase_d = cmd_i.is_q ? PH_SKIP : PH_START;
            end
            PH_SKIP: begin
              phase_d = PH_START;
            end
            PH_AFTER_HI: begin
              if (!cmd_i.is_space && !ovf_q && (len_q != '0)) begin
                pat_byte_d[0] = pat_byte_q[0] | cmd_i.digit;
              end
              phase_d = PH_START;
            end
            default: begin
              if (cmd_i.is_q) begin
                app_en   = 1'b1;
                app_wild = 1'b1;
                phase_d  = PH_AFTER_Q;
              end else if (!cmd_i.is_space) begin
                app_en   = 1'b1;
                app_byte = {cmd_i.digit[3:0], 4'h0} & HighNibMask;
                phase_d  = PH_AFTER_HI;
              end
            end
          endcase
        end
        CMD_BYTE: begin
          if (!done_q) begin
            win_d  = win_n;
            seen_d = seen_n;
            if (hit) begin
              res_load       = 1'b1;
              res_d.found    = 1'b1;
              res_d.overflow = ovf_q;
              res_d.offset   = off;
              done_d         = 1'b1;
            end else if (cmd_i.last) begin
              res_load       = 1'b1;
              res_d.found    = 1'b0;
              res_d.overflow = ovf_q;
              res_d.offset   = '0;
            end
          end
          if (cmd_i.last) begin
            seen_d = '0;
            done_d = 1'b0;
          end
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
    // Append an element or flag the drop
    if (app_en) begin
      if (len_q < LenW'(MaxPattern)) begin
        for (int j = 1; j < MaxPattern; j++) begin
          pat_byte_d[j] = pat_byte_q[j-1];
          pat_wild_d[j] = pat_wild_q[j-1];
        end
        pat_byte_d[0] = app_byte;
        pat_wild_d[0] = app_wild;
        len_d         = len_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Result stage and output register
  always_comb begin
    res_valid_d = res_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_addr_d  = out_addr_q;
    if (res_move) begin
      res_valid_d = 1'b0;
    end
    if (res_load) begin
      res_valid_d = 1'b1;
    end
    if (res_move) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
      out_addr_d  = res_q.found ? region_base_i + 64'(res_q.offset) : '0;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      phase_q     <= PH_START;
      ovf_q       <= 1'b0;
      seen_q      <= '0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      phase_q     <= phase_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: pattern, window and result data
  always_ff @(posedge clk_i) begin
    pat_byte_q <= pat_byte_d;
    pat_wild_q <= pat_wild_d;
    win_q      <= win_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_addr_q <= out_addr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_addr_q, out_q.offset};
  assign m_axis_tuser  = {out_q.overflow, out_q.found};

endmodule

### rtl/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner: APB register, front end,
// command queue and scan engine. Depends on wbps_pkg, wbps_front, wbps_fifo, wbps_back.
//
//   Port group  Dir   Payload (low bit up)
//   s_axis      in    tdata[7:0] value; tuser[1:0] opcode; tlast last
//   m_axis      out   tdata offset[31:0], address[95:32]; tuser found[0], overflow[1]
//   apb         in    region_base at byte address 0, 64-bit data
//
// One item per cycle while the result stream is not stalled; the masked window compare
// and the pattern update of the scan engine are combinational.
// The queue is written at the accepting edge; a result then passes the engine's
// result stage and the output register before it is valid on m_axis.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result stream fills the result stage, then the queue, then drops tready.
module wildcard_byte_pattern_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // value[7:0]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // offset[31:0], address[95:32]
  output logic [1:0]  m_axis_tuser,   // found[0], overflow[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import wbps_pkg::*;

  logic [63:0] base_q;
  logic        cfg_wr;
  logic        push, full, cmd_valid, pop;
  cmd_t        push_cmd, head_cmd;

  // Hold the region base register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == RegIdxRegionBase) ? base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr && (paddr[3] == RegIdxRegionBase)) begin
      base_q <= pwdata;
    end
  end

  wbps_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  wbps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .data_o  (head_cmd),
    .pop_i   (pop)
  );

  wbps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .region_base_i (base_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
